// ===== design/pla_pkg.sv =====
// Package for the point-pair link block: payload structs, CSR codes and widths.
// No dependencies; imported by proximity_link_alpha.
package pla_pkg;

   localparam int COORD_BITS  = 16;
   localparam int FIELD_BITS  = 16;
   localparam int COORD_USED  = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
   localparam int SQ_BITS     = 2 * COORD_USED;
   localparam int D2_BITS     = SQ_BITS + 1;
   localparam int RADIUS_BITS = 16;
   localparam int ALPHA_BITS  = 8;
   localparam int R2_BITS     = 2 * RADIUS_BITS;
   localparam int CMP_BITS    = (D2_BITS > R2_BITS) ? D2_BITS : R2_BITS;
   localparam int ROOT_BITS   = RADIUS_BITS;
   localparam int REM_BITS    = ROOT_BITS + 1;
   localparam int NUM_BITS    = RADIUS_BITS + ALPHA_BITS;
   localparam int CSR_DATA_BITS = RADIUS_BITS;

   typedef enum logic [0:0] {
      CSR_LINK_RADIUS = 1'b0,
      CSR_LINE_ALPHA  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] ax;
      logic [FIELD_BITS-1:0] ay;
      logic [FIELD_BITS-1:0] bx;
      logic [FIELD_BITS-1:0] by;
   } req_type;

   typedef struct packed {
      logic                  linked;
      logic [ALPHA_BITS-1:0] alpha;
   } rsp_type;

   typedef struct packed {
      logic [REM_BITS-1:0]  rem;
      logic [ROOT_BITS-1:0] root;
   } sqrt_step_type;

endpackage

// ===== design/proximity_link_alpha.sv =====
// Point-pair link test with distance-faded line opacity, fully pipelined.
// Depends on pla_pkg for payload structs, CSR codes and widths.
//
// One point pair is taken per clock (start while busy is low; busy stays low) and its result
// appears on rsp_data with rsp_strobe, one result per pair, in order. The pipeline holds
// absolute differences, squaring, the sum and radius compare, eight square-root stages
// producing two root bits each, the (R - d) * A multiply, and four divider stages producing
// two quotient bits each. The receiver cannot stall, so results are never held back. Write
// link_radius and line_alpha only when no pair is in flight; a new radius reaches the compare
// via the registered r2_ff; the root subtraction and the divider read radius_ff directly.
module proximity_link_alpha
   import pla_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_data,
   output logic                     rsp_strobe,
   output rsp_type                  rsp_data,
   input  logic                     csr_we,
   input  csr_index_type            csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int SQRT_STAGES = ROOT_BITS / 2;
   localparam int DIV_STAGES  = ALPHA_BITS / 2;
   localparam int LATENCY     = 3 + SQRT_STAGES + 1 + DIV_STAGES;

   function automatic sqrt_step_type sqrt_step(input sqrt_step_type cur,
                                               input logic [1:0] pair);
      logic [REM_BITS+1:0] rem_sh;
      logic [REM_BITS+1:0] trial;
      sqrt_step_type       nxt;
      rem_sh = {cur.rem, pair};
      trial  = {1'b0, cur.root, 2'b01};
      if (rem_sh >= trial) begin
         nxt.rem  = REM_BITS'(rem_sh - trial);
         nxt.root = {cur.root[ROOT_BITS-2:0], 1'b1};
      end else begin
         nxt.rem  = rem_sh[REM_BITS-1:0];
         nxt.root = {cur.root[ROOT_BITS-2:0], 1'b0};
      end
      return nxt;
   endfunction

   // configuration
   logic [RADIUS_BITS-1:0] radius_ff;
   logic [ALPHA_BITS-1:0]  line_alpha_ff;
   logic [R2_BITS-1:0]     r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff     <= RADIUS_BITS'(2400);
         line_alpha_ff <= ALPHA_BITS'(255);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LINK_RADIUS: radius_ff     <= csr_wdata[RADIUS_BITS-1:0];
            CSR_LINE_ALPHA:  line_alpha_ff <= csr_wdata[ALPHA_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      r2_ff <= radius_ff * radius_ff;
   end

   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // stage 1: absolute differences
   logic                  p1_vld_ff;
   logic [COORD_USED-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [COORD_USED-1:0] ax_m, ay_m, bx_m, by_m;

   always_comb begin
      ax_m  = req_data.ax[COORD_USED-1:0];
      ay_m  = req_data.ay[COORD_USED-1:0];
      bx_m  = req_data.bx[COORD_USED-1:0];
      by_m  = req_data.by[COORD_USED-1:0];
      dx_in = (ax_m >= bx_m) ? (ax_m - bx_m) : (bx_m - ax_m);
      dy_in = (ay_m >= by_m) ? (ay_m - by_m) : (by_m - ay_m);
   end

   // stage 2: squares
   logic               p2_vld_ff;
   logic [SQ_BITS-1:0] sqx_ff, sqy_ff;

   // stage 3: sum, radius compare, root input
   logic [D2_BITS-1:0]   d2;
   logic                 lnk_in;

   always_comb begin
      d2     = D2_BITS'(sqx_ff) + D2_BITS'(sqy_ff);
      lnk_in = CMP_BITS'(d2) < CMP_BITS'(r2_ff);
   end

   // square-root stages: index 0 is the stage 3 output
   logic                 sq_vld_ff [SQRT_STAGES+1];
   logic                 sq_lnk_ff [SQRT_STAGES+1];
   logic [R2_BITS-1:0]   sq_val_ff [SQRT_STAGES+1];
   sqrt_step_type        sq_st_ff  [SQRT_STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         sq_vld_ff[0] <= 1'b0;
      end else begin
         p1_vld_ff    <= accept;
         p2_vld_ff    <= p1_vld_ff;
         sq_vld_ff[0] <= p2_vld_ff;
      end
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      sqx_ff       <= dx_ff * dx_ff;
      sqy_ff       <= dy_ff * dy_ff;
      sq_lnk_ff[0] <= lnk_in;
      // feed zero for unlinked pairs; a linked d2 always fits the root input
      sq_val_ff[0] <= lnk_in ? R2_BITS'(d2) : '0;
      sq_st_ff[0]  <= '0;
   end

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_sqrt
      localparam int P0 = ROOT_BITS - 1 - 2 * s;
      localparam int P1 = P0 - 1;
      sqrt_step_type mid, nxt;

      always_comb begin
         mid = sqrt_step(sq_st_ff[s], sq_val_ff[s][2*P0+1 -: 2]);
         nxt = sqrt_step(mid, sq_val_ff[s][2*P1+1 -: 2]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[s+1] <= 1'b0;
         end else begin
            sq_vld_ff[s+1] <= sq_vld_ff[s];
         end
         sq_lnk_ff[s+1] <= sq_lnk_ff[s];
         sq_val_ff[s+1] <= sq_val_ff[s];
         sq_st_ff[s+1]  <= nxt;
      end
   end

   // multiply stage: numerator (R - d) * A
   logic                  mul_vld_ff;
   logic                  mul_lnk_ff;
   logic [NUM_BITS-1:0]   mul_num_ff;
   logic [RADIUS_BITS-1:0] span;

   assign span = radius_ff - sq_st_ff[SQRT_STAGES].root;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else begin
         mul_vld_ff <= sq_vld_ff[SQRT_STAGES];
      end
      mul_lnk_ff <= sq_lnk_ff[SQRT_STAGES];
      mul_num_ff <= span * line_alpha_ff;
   end

   // divider stages, restoring, quotient bits MSB first; index 0 is the multiply output
   logic                  dv_vld_ff [DIV_STAGES+1];
   logic                  dv_lnk_ff [DIV_STAGES+1];
   logic [NUM_BITS-1:0]   dv_rem_ff [DIV_STAGES+1];
   logic [ALPHA_BITS-1:0] dv_q_ff   [DIV_STAGES+1];

   assign dv_vld_ff[0] = mul_vld_ff;
   assign dv_lnk_ff[0] = mul_lnk_ff;
   assign dv_rem_ff[0] = mul_num_ff;
   assign dv_q_ff[0]   = '0;

   for (genvar t = 0; t < DIV_STAGES; t++) begin : g_div
      localparam int I0 = ALPHA_BITS - 1 - 2 * t;
      localparam int I1 = I0 - 1;
      logic [NUM_BITS-1:0]   sh0, sh1, rem_mid, rem_in;
      logic                  ge0, ge1;
      logic [ALPHA_BITS-1:0] q_in;

      always_comb begin
         sh0     = NUM_BITS'(radius_ff) << I0;
         sh1     = NUM_BITS'(radius_ff) << I1;
         ge0     = dv_rem_ff[t] >= sh0;
         rem_mid = ge0 ? (dv_rem_ff[t] - sh0) : dv_rem_ff[t];
         ge1     = rem_mid >= sh1;
         rem_in  = ge1 ? (rem_mid - sh1) : rem_mid;
         q_in    = {dv_q_ff[t][ALPHA_BITS-3:0], ge0, ge1};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[t+1] <= 1'b0;
         end else begin
            dv_vld_ff[t+1] <= dv_vld_ff[t];
         end
         dv_lnk_ff[t+1] <= dv_lnk_ff[t];
         dv_rem_ff[t+1] <= rem_in;
         dv_q_ff[t+1]   <= q_in;
      end
   end

   // drop the quotient of unlinked pairs
   assign rsp_strobe      = dv_vld_ff[DIV_STAGES];
   assign rsp_data.linked = dv_lnk_ff[DIV_STAGES];
   assign rsp_data.alpha  = dv_lnk_ff[DIV_STAGES] ? dv_q_ff[DIV_STAGES] : '0;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("transaction result missing at fixed latency");

   a_root_below_radius : assert property (@(posedge clock) disable iff (reset)
      sq_vld_ff[SQRT_STAGES] && sq_lnk_ff[SQRT_STAGES]
         |-> sq_st_ff[SQRT_STAGES].root < radius_ff)
      else $error("root of a linked pair not below radius");

   a_alpha_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.linked |-> rsp_data.alpha <= line_alpha_ff)
      else $error("alpha exceeds base alpha");

   a_strobe_source : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(sq_vld_ff[SQRT_STAGES], DIV_STAGES + 1))
      else $error("result strobe without a transaction behind it");

endmodule
